FILE: rtl/core/mas_pkg.sv
// ----------------------------------------------------------------------------
// mas_pkg
// Shared constants, codes and types of the arpeggiator sequencer.
// ----------------------------------------------------------------------------
package mas_pkg;

	localparam int SET_CAPACITY_DEF = 16;
	localparam int MAX_BLOCK_DEF    = 4096;

	localparam int NOTE_W   = 7;
	localparam int COUNT_W  = 13;
	localparam int OFFSET_W = 12;
	localparam int PER_W    = 20;
	localparam int SUM_W    = PER_W + 1;

	localparam logic [PER_W-1:0] STEP_PERIOD_RST = PER_W'(22050);

	localparam logic [1:0] REQ_NOTE_ON  = 2'd0;
	localparam logic [1:0] REQ_NOTE_OFF = 2'd1;
	localparam logic [1:0] REQ_TICK     = 2'd2;

	localparam logic [1:0] MODE_ASC  = 2'd0;
	localparam logic [1:0] MODE_DESC = 2'd1;
	localparam logic [1:0] MODE_SAND = 2'd2;

	localparam logic [1:0] REG_ARP_MODE    = 2'd0;
	localparam logic [1:0] REG_OCTAVE_SPAN = 2'd1;
	localparam logic [1:0] REG_STEP_PERIOD = 2'd2;

	localparam logic EV_OFF = 1'b0;
	localparam logic EV_ON  = 1'b1;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_CMP,
		CELL_INS,
		CELL_REM
	} cell_op_t;

	typedef struct packed {
		cell_op_t            op;
		logic [NOTE_W-1:0]   key;
	} cell_ctl_t;

endpackage

FILE: rtl/core/mas_if.sv
// ----------------------------------------------------------------------------
// mas_if
// Request and event channels of the arpeggiator sequencer.
// ----------------------------------------------------------------------------
interface mas_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [6:0]  note;
	logic [12:0] sample_count;

	modport source (output valid, req_type, note, sample_count, input ready);
	modport sink   (input valid, req_type, note, sample_count, output ready);
endinterface

interface mas_evt_if;
	logic        valid;
	logic        ready;
	logic        event_kind;
	logic [6:0]  out_note;
	logic [11:0] sample_offset;
	logic        last;

	modport source (output valid, event_kind, out_note, sample_offset, last, input ready);
	modport sink   (input valid, event_kind, out_note, sample_offset, last, output ready);
endinterface

FILE: rtl/core/mas_cell.sv
// ----------------------------------------------------------------------------
// mas_cell
// One slot of the sorted note chain: compares against a key, then takes
// the key or a neighbor's value on insert and remove.
// ----------------------------------------------------------------------------
module mas_cell #(
	parameter int IDX = 0,
	parameter int CW  = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mas_pkg::cell_ctl_t ctl,
	input  logic [CW-1:0]      count,
	input  logic [6:0]         left_val,
	input  logic               left_lt,
	input  logic [6:0]         right_val,
	output logic [6:0]         val,
	output logic               lt,
	output logic               eq
);
	import mas_pkg::*;

	logic [6:0] val_q;
	logic       lt_q;
	logic       eq_q;
	logic       in_set;
	logic       upto_end;

	assign in_set   = CW'(IDX) < count;
	assign upto_end = CW'(IDX) <= count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctl.op == CELL_CMP) begin
			lt_q <= in_set && (val_q < ctl.key);
			eq_q <= in_set && (val_q == ctl.key);
		end
	end

	// entries >= key move up one place on insert, down on remove
	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_INS: begin
				if (upto_end && !lt_q) begin
					val_q <= left_lt ? ctl.key : left_val;
				end
			end
			CELL_REM: begin
				if (in_set && !lt_q) begin
					val_q <= right_val;
				end
			end
			default: ;
		endcase
	end

	assign val = val_q;
	assign lt  = lt_q;
	assign eq  = eq_q;

endmodule

FILE: rtl/core/mas_mod.sv
// ----------------------------------------------------------------------------
// mas_mod
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module mas_mod #(
	parameter int DW = 21,
	parameter int VW = 20
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          busy,
	output logic          done,
	output logic [VW-1:0] rem
);
	localparam int CNW = $clog2(DW + 1);

	logic [CNW-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [DW-1:0]  dvd_q;
	logic [VW-1:0]  dvs_q;
	logic [VW:0]    rem_q;
	logic [VW:0]    trial;
	logic           fits;

	assign trial = {rem_q[VW-1:0], dvd_q[DW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNW'(1);
				if (cnt_q == CNW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= fits ? (trial - {1'b0, dvs_q}) : trial;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rem  = rem_q[VW-1:0];

endmodule

FILE: rtl/core/midi_arpeggiator_sequencer_unit.sv
// ----------------------------------------------------------------------------
// midi_arpeggiator_sequencer_unit
// Sorted held-note chain with an arpeggio step sequencer on audio ticks.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   req_type, note, sample_count
//   evt      out  valid/ready   event_kind, out_note, sample_offset, last
//   apb      in   psel/penable  arp_mode, octave_span, step_period
//
// note on/off: a compare state and a commit state per octave copy,
// octave_span+1 copies in all; a tick that steps runs the one-bit-a-cycle
// remainder unit once for the phase and once for the step index; a tick
// that does not step runs it for the phase only
// reset clears counts and flags; the note chain holds no reset values
// one request is worked at a time; a held event stalls only a stepping tick
// ----------------------------------------------------------------------------
module midi_arpeggiator_sequencer_unit #(
	parameter int SET_CAPACITY = mas_pkg::SET_CAPACITY_DEF,
	parameter int MAX_BLOCK    = mas_pkg::MAX_BLOCK_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	mas_req_if.sink     req,
	mas_evt_if.source   evt
);
	import mas_pkg::*;

	localparam int CW   = $clog2(SET_CAPACITY + 1);
	localparam int IW   = $clog2(SET_CAPACITY);
	localparam int NMAX = (MAX_BLOCK < 8191) ? MAX_BLOCK : 8191;

	typedef enum logic [2:0] {
		S_IDLE,
		S_NCMP,
		S_NCOMMIT,
		S_TOFF,
		S_TMOD,
		S_IMOD,
		S_IREAD,
		S_EMIT
	} state_t;

	state_t            state_q;
	logic [1:0]        arp_mode_q;
	logic [2:0]        octave_span_q;
	logic [PER_W-1:0]  step_period_q;

	logic [CW-1:0]     held_count_q;
	logic [IW-1:0]     step_index_q;
	logic [PER_W-1:0]  phase_q;
	logic [6:0]        sounding_note_q;
	logic              sounding_valid_q;

	logic              is_ins_q;
	logic [7:0]        v_q;
	logic [2:0]        k_q;

	logic [SUM_W-1:0]  sum_q;
	logic [PER_W-1:0]  period_q;
	logic [COUNT_W-1:0] n_q;
	logic              fire_q;
	logic [OFFSET_W-1:0] off_q;

	logic              mod_start_q;
	logic [SUM_W-1:0]  mod_a_q;
	logic [PER_W-1:0]  mod_b_q;
	logic              mod_busy;
	logic              mod_done;
	logic [PER_W-1:0]  mod_rem;

	logic              slot_kind_q [2];
	logic [6:0]        slot_note_q [2];
	logic [1:0]        pend_q;
	logic              e_q;

	logic              evt_valid_q;
	logic              evt_kind_q;
	logic [6:0]        evt_note_q;
	logic [OFFSET_W-1:0] evt_off_q;
	logic              evt_last_q;

	cell_ctl_t         ctl;
	logic [6:0]        vals [SET_CAPACITY];
	logic [SET_CAPACITY-1:0] lts;
	logic [SET_CAPACITY-1:0] eqs;

	logic              cfg_wr;
	logic              accept;
	logic              dup;
	logic              v_ok;
	logic              ins_ok;
	logic              rem_ok;
	logic [COUNT_W-1:0] n_sat;
	logic [PER_W-1:0]  period_in;
	logic [PER_W-1:0]  diff;
	logic [COUNT_W-1:0] nm1;
	logic [COUNT_W-1:0] off_c;
	logic [CW-1:0]     ic;
	logic [CW-1:0]     half;
	logic [CW-1:0]     nxt;
	logic              is_last;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arp_mode_q    <= MODE_ASC;
			octave_span_q <= '0;
			step_period_q <= STEP_PERIOD_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_ARP_MODE:    arp_mode_q    <= pwdata[1:0];
				REG_OCTAVE_SPAN: octave_span_q <= pwdata[2:0];
				REG_STEP_PERIOD: step_period_q <= pwdata[PER_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_ARP_MODE:    prdata = {30'd0, arp_mode_q};
			REG_OCTAVE_SPAN: prdata = {29'd0, octave_span_q};
			REG_STEP_PERIOD: prdata = {12'd0, step_period_q};
			default:         prdata = '0;
		endcase
	end

	// note chain
	assign dup    = |eqs;
	assign v_ok   = v_q <= 8'd127;
	assign ins_ok = v_ok && !dup && (held_count_q < CW'(SET_CAPACITY));
	assign rem_ok = v_ok && dup;

	always_comb begin
		ctl.key = v_q[6:0];
		case (state_q)
			S_NCMP:    ctl.op = CELL_CMP;
			S_NCOMMIT: begin
				if (is_ins_q) begin
					ctl.op = ins_ok ? CELL_INS : CELL_HOLD;
				end else begin
					ctl.op = rem_ok ? CELL_REM : CELL_HOLD;
				end
			end
			default:   ctl.op = CELL_HOLD;
		endcase
	end

	for (genvar g = 0; g < SET_CAPACITY; g++) begin : g_cell
		logic [6:0] lv;
		logic       ll;
		logic [6:0] rv;
		if (g == 0) begin : g_first
			assign lv = vals[g];
			assign ll = 1'b1;
		end else begin : g_mid
			assign lv = vals[g-1];
			assign ll = lts[g-1];
		end
		if (g == SET_CAPACITY - 1) begin : g_tail
			assign rv = vals[g];
		end else begin : g_body
			assign rv = vals[g+1];
		end
		mas_cell #(.IDX(g), .CW(CW)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.count     (held_count_q),
			.left_val  (lv),
			.left_lt   (ll),
			.right_val (rv),
			.val       (vals[g]),
			.lt        (lts[g]),
			.eq        (eqs[g])
		);
	end

	mas_mod #(.DW(SUM_W), .VW(PER_W)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start_q),
		.dividend (mod_a_q),
		.divisor  (mod_b_q),
		.busy     (mod_busy),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// tick arithmetic
	assign n_sat     = (32'(req.sample_count) > NMAX) ? COUNT_W'(NMAX) : req.sample_count;
	assign period_in = (step_period_q == '0) ? PER_W'(1) : step_period_q;
	assign diff      = period_q - phase_q;
	assign nm1       = n_q - COUNT_W'(1);

	always_comb begin
		if (phase_q >= period_q) begin
			off_c = '0;
		end else if (diff > PER_W'(nm1)) begin
			off_c = nm1;
		end else begin
			off_c = diff[COUNT_W-1:0];
		end
	end

	// next step index from the reduced index
	assign ic   = CW'(mod_rem[IW-1:0]);
	assign half = held_count_q >> 1;

	always_comb begin
		case (arp_mode_q)
			MODE_ASC:  nxt = (ic + CW'(1) == held_count_q) ? '0 : ic + CW'(1);
			MODE_DESC: nxt = (ic == '0) ? held_count_q - CW'(1) : ic - CW'(1);
			MODE_SAND: begin
				if (ic < half) begin
					nxt = held_count_q - CW'(1) - ic;
				end else if (ic > half) begin
					nxt = held_count_q - ic;
				end else begin
					nxt = '0;
				end
			end
			default:   nxt = ic;
		endcase
	end

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign is_last   = ({1'b0, e_q} == pend_q - 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			held_count_q     <= '0;
			step_index_q     <= '0;
			phase_q          <= '0;
			sounding_note_q  <= '0;
			sounding_valid_q <= 1'b0;
			mod_start_q      <= 1'b0;
			pend_q           <= '0;
			e_q              <= 1'b0;
			evt_valid_q      <= 1'b0;
			is_ins_q         <= 1'b0;
			k_q              <= '0;
			fire_q           <= 1'b0;
		end else begin
			mod_start_q <= 1'b0;
			if (evt_valid_q && evt.ready) begin
				evt_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.req_type == REQ_NOTE_ON || req.req_type == REQ_NOTE_OFF) begin
							is_ins_q <= (req.req_type == REQ_NOTE_ON);
							v_q      <= {1'b0, req.note};
							k_q      <= '0;
							state_q  <= S_NCMP;
						end else if (req.req_type == REQ_TICK && req.sample_count != '0) begin
							n_q      <= n_sat;
							period_q <= period_in;
							sum_q    <= {1'b0, phase_q} + SUM_W'(n_sat);
							state_q  <= S_TOFF;
						end
					end
				end
				S_NCMP: state_q <= S_NCOMMIT;
				S_NCOMMIT: begin
					if (is_ins_q && ins_ok) begin
						held_count_q <= held_count_q + CW'(1);
					end else if (!is_ins_q && rem_ok) begin
						held_count_q <= held_count_q - CW'(1);
					end
					if (k_q == octave_span_q) begin
						state_q <= S_IDLE;
					end else begin
						k_q     <= k_q + 3'd1;
						v_q     <= v_q + 8'd12;
						state_q <= S_NCMP;
					end
				end
				S_TOFF: begin
					fire_q      <= sum_q >= {1'b0, period_q};
					off_q       <= off_c[OFFSET_W-1:0];
					pend_q      <= '0;
					e_q         <= 1'b0;
					mod_a_q     <= sum_q;
					mod_b_q     <= period_q;
					mod_start_q <= 1'b1;
					state_q     <= S_TMOD;
				end
				S_TMOD: begin
					if (mod_done) begin
						phase_q <= mod_rem;
						if (!fire_q) begin
							state_q <= S_IDLE;
						end else begin
							if (sounding_valid_q) begin
								slot_kind_q[0]   <= EV_OFF;
								slot_note_q[0]   <= sounding_note_q;
								pend_q           <= 2'd1;
								sounding_valid_q <= 1'b0;
							end
							if (held_count_q != '0) begin
								mod_a_q     <= SUM_W'(step_index_q);
								mod_b_q     <= PER_W'(held_count_q);
								mod_start_q <= 1'b1;
								state_q     <= S_IMOD;
							end else begin
								state_q <= S_EMIT;
							end
						end
					end
				end
				S_IMOD: begin
					if (mod_done) begin
						step_index_q <= nxt[IW-1:0];
						state_q      <= S_IREAD;
					end
				end
				S_IREAD: begin
					sounding_note_q       <= vals[step_index_q];
					sounding_valid_q      <= 1'b1;
					slot_kind_q[pend_q[0]] <= EV_ON;
					slot_note_q[pend_q[0]] <= vals[step_index_q];
					pend_q                <= pend_q + 2'd1;
					state_q               <= S_EMIT;
				end
				S_EMIT: begin
					if (pend_q == '0) begin
						state_q <= S_IDLE;
					end else if (!evt_valid_q || evt.ready) begin
						evt_valid_q <= 1'b1;
						evt_kind_q  <= slot_kind_q[e_q];
						evt_note_q  <= slot_note_q[e_q];
						evt_off_q   <= off_q;
						evt_last_q  <= is_last;
						if (is_last) begin
							state_q <= S_IDLE;
						end else begin
							e_q <= 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign evt.valid         = evt_valid_q;
	assign evt.event_kind    = evt_kind_q;
	assign evt.out_note      = evt_note_q;
	assign evt.sample_offset = evt_off_q;
	assign evt.last          = evt_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q <= CW'(SET_CAPACITY))
		else $error("held count above capacity");

	a_mod_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		mod_start_q |-> !mod_busy)
		else $error("remainder unit started while busy");

	a_mod_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> (state_q == S_TMOD || state_q == S_IMOD))
		else $error("remainder result outside a waiting state");

endmodule
